FILE: sv/hbs_pkg.sv
`timescale 1ns / 1ps
// Package for the histogram engine with binomial smoothing.
// Holds shared constants, opcode, configuration index and state types, and the cell control struct.
package hbs_pkg;

  localparam int unsigned MaxBinsDefault = 128;
  localparam logic [7:0]  BinsInUseReset = 8'd100;
  localparam logic [30:0] BinWidthReset  = 31'd65536;
  localparam logic [31:0] BinIncrement   = 32'd256;

  typedef enum logic [1:0] {
    OP_BIN    = 2'd0,
    OP_SMOOTH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_BINS_IN_USE = 2'd0,
    CFG_BIN_WIDTH   = 2'd1,
    CFG_SPARE2      = 2'd2,
    CFG_SPARE3      = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SMOOTH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic smooth;
    logic first;
    logic last;
    logic active;
    logic inc;
  } cell_ctrl_t;

endpackage

FILE: sv/hbs_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the histogram engine: input, result and configuration.
// Depends on nothing.
interface hbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] sample_value;
  logic [7:0]         pass_count;
  logic [6:0]         read_index;
  modport source(output valid, opcode, sample_value, pass_count, read_index, input ready);
  modport sink(input valid, opcode, sample_value, pass_count, read_index, output ready);
endinterface

interface hbs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_value;
  logic [31:0] miss_total;
  logic        was_miss;
  modport source(output valid, bin_value, miss_total, was_miss, input ready);
  modport sink(input valid, bin_value, miss_total, was_miss, output ready);
endinterface

interface hbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/hbs_cell.sv
`timescale 1ns / 1ps
// One bin of the histogram chain: holds a Q24.8 count, increments it and runs
// one 1-2-1 smoothing step per cycle from its neighbors. Depends on hbs_pkg.
module hbs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hbs_pkg::cell_ctrl_t ctrl_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  output logic [31:0]         value_o
);

  logic [31:0] value_q, value_d;
  logic [31:0] a, b;
  logic [33:0] sum;
  logic [32:0] inc_sum;

  always_comb begin
    a       = ctrl_i.first ? value_q : left_i;
    b       = ctrl_i.last ? value_q : right_i;
    sum     = {2'b00, a} + {1'b0, value_q, 1'b0} + {2'b00, b};
    inc_sum = {1'b0, value_q} + {1'b0, hbs_pkg::BinIncrement};
    value_d = value_q;
    if (ctrl_i.smooth && ctrl_i.active) begin
      value_d = sum[33:2];
    end else if (ctrl_i.inc) begin
      value_d = inc_sum[32] ? 32'hFFFF_FFFF : inc_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

FILE: sv/hbs_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for 31-bit unsigned operands.
// Depends on nothing beyond the clock and reset.
module hbs_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [30:0] quotient_o
);

  logic [31:0] rem_q, rem_d;
  logic [30:0] dq_q, dq_d;
  logic [30:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial  = {rem_q[30:0], dq_q[30]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[32]) begin
        rem_d = trial;
        dq_d  = {dq_q[29:0], 1'b0};
      end else begin
        rem_d = diff[31:0];
        dq_d  = {dq_q[29:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd30) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: sv/histogram_binning_with_smoothing.sv
`timescale 1ns / 1ps
// Histogram engine with 1-2-1 binomial smoothing, top level.
// Depends on hbs_pkg, the channel interfaces, hbs_cell and hbs_divider.
//
// Usage: configuration words arrive on cfg_i (index 0 bins in use, index 1 bin
// width in Q15.16) and are taken in every cycle; the user must see that they are
// written only while no word is in flight, as the block does not enforce this.
// Input words on in_i carry an opcode: bin a sample, smooth, or read one bin.
// Every input word yields exactly one result word on out_o.
// The block works on one word at a time. A read or an unused opcode goes
// from idle straight to the done state. A sample with a nonnegative value
// and nonzero width goes through the bit-serial divider first; other samples
// go straight to done. Smoothing runs one pass per cycle over the chain of
// bin cells, pass_count passes in all, when at least two bins are active.
// The result sits in an output register; while the receiver stalls the block
// holds the finished word and takes no new input word.
// Reset clears all bins, the miss counter and the registers to their
// defaults (100 bins, width 1.0) at once; no clearing pass is needed.
module histogram_binning_with_smoothing #(
  parameter int unsigned MAX_BINS = hbs_pkg::MaxBinsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hbs_in_if.sink    in_i,
  hbs_out_if.source out_o,
  hbs_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW = ($clog2(MAX_BINS + 1) > 8) ? $clog2(MAX_BINS + 1) : 8;

  hbs_pkg::state_e state_q, state_d;

  logic [7:0]    bins_q;
  logic [30:0]   width_q;
  logic [31:0]   miss_q, miss_d;
  logic [NW-1:0] n_act;
  logic [7:0]    passes_q, passes_d;
  logic [31:0]   res_value_q, res_value_d;
  logic          res_miss_q, res_miss_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_value_q, out_miss_q;
  logic          out_was_q;
  logic          load_out;
  logic          div_start, div_done;
  logic [30:0]   quotient;
  logic          q_hit;
  logic [IW-1:0] inc_idx;
  logic          inc_en;
  logic          smooth_en;
  logic [31:0]   cell_val [MAX_BINS];
  logic [31:0]   rd_val;
  logic          accept;
  logic [31:0]   miss_inc;

  assign n_act = (NW'(bins_q) > NW'(MAX_BINS)) ? NW'(MAX_BINS) : NW'(bins_q);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q  <= hbs_pkg::BinsInUseReset;
      width_q <= hbs_pkg::BinWidthReset;
    end else if (cfg_i.valid) begin
      unique case (hbs_pkg::cfg_index_e'(cfg_i.index))
        hbs_pkg::CFG_BINS_IN_USE: bins_q <= cfg_i.data[7:0];
        hbs_pkg::CFG_BIN_WIDTH:   width_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  hbs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.sample_value[30:0]),
    .divisor_i  (width_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_hit   = {1'b0, quotient} < 32'(n_act);
  assign inc_idx = quotient[IW-1:0];
  assign inc_en  = (state_q == hbs_pkg::S_DIV) && div_done && q_hit;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    hbs_pkg::cell_ctrl_t ctrl;
    logic [31:0] left, right;
    assign ctrl.smooth = smooth_en;
    assign ctrl.first  = (i == 0);
    assign ctrl.last   = (NW'(i + 1) == n_act);
    assign ctrl.active = (NW'(i) < n_act);
    assign ctrl.inc    = inc_en && (inc_idx == IW'(i));
    assign left  = (i == 0) ? 32'd0 : cell_val[(i == 0) ? 0 : i - 1];
    assign right = (i == MAX_BINS - 1) ? 32'd0
                                       : cell_val[(i == MAX_BINS - 1) ? i : i + 1];
    hbs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i])
    );
  end

  always_comb begin
    rd_val = '0;
    for (int k = 0; k < MAX_BINS; k++) begin
      if ({{(32-7){1'b0}}, in_i.read_index} == 32'(k)) begin
        rd_val = cell_val[k];
      end
    end
  end

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == hbs_pkg::S_IDLE);
  assign load_out  = (state_q == hbs_pkg::S_DONE) && (!out_valid_q || out_o.ready);
  assign miss_inc  = (miss_q == 32'hFFFF_FFFF) ? miss_q : miss_q + 32'd1;

  always_comb begin
    state_d     = state_q;
    miss_d      = miss_q;
    passes_d    = passes_q;
    res_value_d = res_value_q;
    res_miss_d  = res_miss_q;
    div_start   = 1'b0;
    smooth_en   = 1'b0;
    unique case (state_q)
      hbs_pkg::S_IDLE: begin
        if (accept) begin
          res_value_d = '0;
          res_miss_d  = 1'b0;
          passes_d    = in_i.pass_count;
          state_d     = hbs_pkg::S_DONE;
          unique case (hbs_pkg::opcode_e'(in_i.opcode))
            hbs_pkg::OP_BIN: begin
              if (in_i.sample_value[31] || (width_q == '0)) begin
                miss_d     = miss_inc;
                res_miss_d = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = hbs_pkg::S_DIV;
              end
            end
            hbs_pkg::OP_SMOOTH: begin
              if (n_act >= NW'(2)) begin
                state_d = hbs_pkg::S_SMOOTH;
              end
            end
            hbs_pkg::OP_READ: begin
              if ({1'b0, in_i.read_index} < 8'(MAX_BINS > 255 ? 255 : MAX_BINS)
                  || MAX_BINS > 127) begin
                res_value_d = rd_val;
              end
            end
            hbs_pkg::OP_NONE: ;
            default: ;
          endcase
        end
      end
      hbs_pkg::S_DIV: begin
        if (div_done) begin
          if (!q_hit) begin
            miss_d     = miss_inc;
            res_miss_d = 1'b1;
          end
          state_d = hbs_pkg::S_DONE;
        end
      end
      hbs_pkg::S_SMOOTH: begin
        if (passes_q == 8'd0) begin
          state_d = hbs_pkg::S_DONE;
        end else begin
          smooth_en = 1'b1;
          passes_d  = passes_q - 8'd1;
        end
      end
      hbs_pkg::S_DONE: begin
        if (load_out) begin
          state_d = hbs_pkg::S_IDLE;
        end
      end
      default: state_d = hbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbs_pkg::S_IDLE;
      miss_q      <= '0;
      passes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      miss_q      <= miss_d;
      passes_q    <= passes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q <= res_value_d;
    res_miss_q  <= res_miss_d;
    if (load_out) begin
      out_value_q <= res_value_q;
      out_miss_q  <= miss_q;
      out_was_q   <= res_miss_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.bin_value  = out_value_q;
  assign out_o.miss_total = out_miss_q;
  assign out_o.was_miss   = out_was_q;

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == hbs_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_miss_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q == 32'hFFFF_FFFF |=> miss_q == 32'hFFFF_FFFF)
    else $error("miss counter left saturation");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("second word taken while one is in flight");

  a_smooth_only_in_smooth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smooth_en |-> n_act >= NW'(2))
    else $error("smoothing pass with fewer than two active bins");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the histogram engine with binomial smoothing.
// Drives the input, result and configuration channels, predicts every result word
// from its own copy of the bins, miss counter and registers, and compares field by field.
module testbench;

  localparam int NumBins = 128;
  localparam int RandItems = 1200;
  localparam longint CycleLimit = 1500000;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] sample;
    logic [7:0]  passes;
    logic [6:0]  ridx;
    logic        has_exp;
    logic [31:0] exp_value;
    logic [31:0] exp_miss_total;
    logic        exp_was_miss;
  } stim_row_t;

  typedef struct {
    logic [31:0] bin_value;
    logic [31:0] miss_total;
    logic        was_miss;
  } hist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  hbs_in_if  in_ch ();
  hbs_out_if out_ch ();
  hbs_cfg_if cfg_ch ();

  histogram_binning_with_smoothing dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] bins_model [NumBins];
  logic [31:0] misses_model;
  logic [7:0]  used_bins;
  logic [30:0] width_q;
  hist_result_t pending_results[$];
  int  errors = 0;
  longint cycles = 0;
  bit  sink_idle_ok = 1'b1;
  int  hold_off = 0;
  int  phase_num = -1;
  bit  long_stall_done = 1'b0;

  function automatic hist_result_t predict_word(input logic [1:0] op, input logic [31:0] smp,
                                                input logic [7:0] np, input logic [6:0] ri);
    hist_result_t r;
    int n;
    logic [31:0] idx;
    logic [33:0] acc;
    logic [31:0] nxt [NumBins];
    r = '{32'd0, 32'd0, 1'b0};
    n = (used_bins > NumBins) ? NumBins : int'(used_bins);
    if (op == hbs_pkg::OP_BIN) begin
      if (smp[31] || width_q == 0) begin
        r.was_miss = 1'b1;
      end else begin
        idx = smp / {1'b0, width_q};
        if (idx >= n) begin
          r.was_miss = 1'b1;
        end else if (bins_model[idx] > 32'hFFFF_FFFF - hbs_pkg::BinIncrement) begin
          bins_model[idx] = 32'hFFFF_FFFF;
        end else begin
          bins_model[idx] = bins_model[idx] + hbs_pkg::BinIncrement;
        end
      end
      if (r.was_miss && misses_model != 32'hFFFF_FFFF) misses_model++;
    end else if (op == hbs_pkg::OP_SMOOTH && n >= 2) begin
      for (int p = 0; p < np; p++) begin
        for (int i = 0; i < n; i++) begin
          if (i == 0) acc = 3 * 34'(bins_model[0]) + bins_model[1];
          else if (i == n - 1) acc = 3 * 34'(bins_model[i]) + bins_model[i - 1];
          else acc = 34'(bins_model[i - 1]) + 2 * 34'(bins_model[i]) + bins_model[i + 1];
          nxt[i] = acc[33:2];
        end
        for (int i = 0; i < n; i++) bins_model[i] = nxt[i];
      end
    end else if (op == hbs_pkg::OP_READ) begin
      r.bin_value = bins_model[ri];
    end
    r.miss_total = misses_model;
    return r;
  endfunction

  task automatic write_reg(input hbs_pkg::cfg_index_e idx, input logic [30:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == hbs_pkg::CFG_BINS_IN_USE) used_bins = val[7:0];
    else if (idx == hbs_pkg::CFG_BIN_WIDTH) width_q = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_word(input stim_row_t row, input bit gaps);
    hist_result_t e;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= row.opcode;
    in_ch.sample_value <= row.sample;
    in_ch.pass_count   <= row.passes;
    in_ch.read_index   <= row.ridx;
    do @(posedge clk_i); while (!in_ch.ready);
    e = predict_word(row.opcode, row.sample, row.passes, row.ridx);
    if (row.has_exp && (e.bin_value !== row.exp_value || e.miss_total !== row.exp_miss_total
        || e.was_miss !== row.exp_was_miss)) begin
      $error("directed row disagrees with prediction, op %0d", row.opcode);
      errors++;
    end
    pending_results.push_back(e);
    @(negedge clk_i);
  endtask

  function automatic stim_row_t mk(input logic [1:0] op, input logic [31:0] smp,
                                   input logic [7:0] np, input logic [6:0] ri);
    stim_row_t row;
    row = '{op, smp, np, ri, 1'b0, 32'd0, 32'd0, 1'b0};
    return row;
  endfunction

  function automatic stim_row_t mkx(input logic [1:0] op, input logic [31:0] smp,
                                    input logic [6:0] ri, input logic [31:0] ev,
                                    input logic [31:0] em, input logic ew);
    stim_row_t row;
    row = '{op, smp, 8'd0, ri, 1'b1, ev, em, ew};
    return row;
  endfunction

  function automatic stim_row_t rand_row(input int nb);
    stim_row_t row;
    int k;
    row = mk(2'($urandom_range(0, 3)), $urandom, 8'($urandom), 7'($urandom));
    k = $urandom_range(0, 9);
    if (k < 6) begin
      row.opcode = hbs_pkg::OP_BIN;
      if (k < 4) row.sample = $urandom_range(0, nb * int'(width_q) + width_q);
    end else if (k < 7) begin
      row.opcode = hbs_pkg::OP_SMOOTH;
      if ($urandom_range(0, 7) != 0) row.passes = 8'($urandom_range(0, 4));
    end else if (k < 9) begin
      row.opcode = hbs_pkg::OP_READ;
    end
    return row;
  endfunction

  always @(posedge clk_i) begin
    hist_result_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.bin_value !== e.bin_value) begin
          $error("bin_value expected %h actual %h", e.bin_value, out_ch.bin_value);
          errors++;
        end
        if (out_ch.miss_total !== e.miss_total) begin
          $error("miss_total expected %h actual %h", e.miss_total, out_ch.miss_total);
          errors++;
        end
        if (out_ch.was_miss !== e.was_miss) begin
          $error("was_miss expected %b actual %b", e.was_miss, out_ch.was_miss);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!long_stall_done && phase_num == 1) begin
      out_ch.ready <= 1'b0;
      hold_off <= 299;
      long_stall_done <= 1'b1;
    end else if (sink_idle_ok && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= $urandom_range(0, 13);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    stim_row_t directed[$];
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = hbs_pkg::OP_NONE;
    in_ch.sample_value = '0;
    in_ch.pass_count = '0;
    in_ch.read_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hbs_pkg::CFG_BINS_IN_USE;
    cfg_ch.data = '0;
    foreach (bins_model[i]) bins_model[i] = '0;
    misses_model = '0;
    used_bins = hbs_pkg::BinsInUseReset;
    width_q = hbs_pkg::BinWidthReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(mkx(hbs_pkg::OP_READ, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'h8000_0000, 7'd0, 32'd0, 32'd1, 1'b1));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'h7FFF_FFFF, 7'd0, 32'd0, 32'd2, 1'b1));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'hFFFF_FFFF, 7'd0, 32'd0, 32'd3, 1'b1));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'd0, 7'd0, 32'd0, 32'd3, 1'b0));
    directed.push_back(mkx(hbs_pkg::OP_READ, 32'd0, 7'd0, 32'd256, 32'd3, 1'b0));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'h0063_FFFF, 7'd0, 32'd0, 32'd3, 1'b0));
    directed.push_back(mkx(hbs_pkg::OP_BIN, 32'h0064_0000, 7'd0, 32'd0, 32'd4, 1'b1));
    directed.push_back(mkx(hbs_pkg::OP_READ, 32'd0, 7'd99, 32'd256, 32'd4, 1'b0));
    directed.push_back(mkx(hbs_pkg::OP_NONE, 32'hFFFF_FFFF, 7'd127, 32'd0, 32'd4, 1'b0));
    directed.push_back(mk(hbs_pkg::OP_SMOOTH, 32'd0, 8'd1, 7'd0));
    directed.push_back(mk(hbs_pkg::OP_READ, 32'd0, 8'd0, 7'd1));
    directed.push_back(mk(hbs_pkg::OP_SMOOTH, 32'd0, 8'd0, 7'd0));
    directed.push_back(mk(hbs_pkg::OP_SMOOTH, 32'd0, 8'd255, 7'd0));
    directed.push_back(mk(hbs_pkg::OP_READ, 32'd0, 8'd0, 7'd127));
    directed.push_back(mk(hbs_pkg::OP_READ, 32'd0, 8'd0, 7'd50));
    foreach (directed[i]) send_word(directed[i], 1'b0);
    wait_drained();

    write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd128);
    write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'h7FFF_FFFF);
    send_word(mk(hbs_pkg::OP_BIN, 32'h7FFF_FFFF, 8'd0, 7'd0), 1'b0);
    send_word(mk(hbs_pkg::OP_BIN, 32'h7FFF_FFFE, 8'd0, 7'd0), 1'b0);
    wait_drained();
    write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'd0);
    send_word(mk(hbs_pkg::OP_BIN, 32'd5, 8'd0, 7'd0), 1'b0);
    wait_drained();
    write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd255);
    write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'd1);
    send_word(mk(hbs_pkg::OP_BIN, 32'd127, 8'd0, 7'd0), 1'b0);
    send_word(mk(hbs_pkg::OP_SMOOTH, 32'd0, 8'd2, 7'd0), 1'b0);
    wait_drained();
    write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd1);
    send_word(mk(hbs_pkg::OP_BIN, 32'd0, 8'd0, 7'd0), 1'b0);
    send_word(mk(hbs_pkg::OP_SMOOTH, 32'd0, 8'd3, 7'd0), 1'b0);
    send_word(mk(hbs_pkg::OP_READ, 32'd0, 8'd0, 7'd0), 1'b0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd2);
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'h0001_0000);
        end
        1: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd128);
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'h0000_4000);
        end
        2: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd17);
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'($urandom));
        end
        3: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd0);
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'd3);
        end
        4: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'd64);
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'd1);
        end
        default: begin
          write_reg(hbs_pkg::CFG_BINS_IN_USE, 31'($urandom_range(2, 128)));
          write_reg(hbs_pkg::CFG_BIN_WIDTH, 31'($urandom_range(1, 300000)));
        end
      endcase
      phase_num = ph;
      if (ph == 5) sink_idle_ok = 1'b0;
      for (int k = 0; k < RandItems / 6; k++) begin
        send_word(rand_row((used_bins > NumBins) ? NumBins : int'(used_bins)), ph != 5);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/hbs_pkg.sv
sv/hbs_if.sv
sv/hbs_cell.sv
sv/hbs_divider.sv
sv/histogram_binning_with_smoothing.sv
tb/sv/testbench.sv
